>>> design/xsrfb_pkg.sv
// Package for the XOR sprite-row framebuffer: action codes, default geometry,
// controller command struct and the visible-pixel mask function.
// No dependencies.
`default_nettype none

package xsrfb_pkg;

  localparam int unsigned DEF_WIDTH  = 64;
  localparam int unsigned DEF_HEIGHT = 32;

  typedef enum logic [1:0] {
    ACT_DRAW  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // take the input item and read its row
    logic commit;  // write back the row and load the result register
  } dp_cmd_t;

  // Mask of the on-screen pixels within byte column col of a row.
  function automatic logic [7:0] vis_mask(input int unsigned col, input int unsigned width);
    int unsigned first;
    int unsigned rem;
    logic [7:0]  m;
    first = col * 8;
    m     = 8'h00;
    if (first < width) begin
      rem = width - first;
      if (rem >= 8) begin
        m = 8'hFF;
      end else begin
        m = 8'(8'hFF << (8 - rem));
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> design/xsrfb_in_if.sv
// Input channel of the framebuffer: valid/ready handshake and one command item.
// Depends on nothing.
`default_nettype none

interface xsrfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] sprite_bits;

  modport source (output valid, output action, output pixel_x, output pixel_y,
                  output sprite_bits, input ready);
  modport sink   (input valid, input action, input pixel_x, input pixel_y,
                  input sprite_bits, output ready);
endinterface

`default_nettype wire

>>> design/xsrfb_out_if.sv
// Result channel of the framebuffer: valid/ready handshake and one result item.
// Depends on nothing.
`default_nettype none

interface xsrfb_out_if;
  logic       valid;
  logic       ready;
  logic       collision;
  logic [7:0] read_byte;

  modport source (output valid, output collision, output read_byte, input ready);
  modport sink   (input valid, input collision, input read_byte, output ready);
endinterface

`default_nettype wire

>>> design/xsrfb_ctrl.sv
// Controller of the framebuffer: sequences accept, row read and write-back,
// and owns the result valid flag. Depends on xsrfb_pkg.
`default_nettype none

module xsrfb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output xsrfb_pkg::dp_cmd_t     cmd
);
  import xsrfb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WB   = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_free   = !out_valid_r || out_ready;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state_r == ST_WB) && out_free;
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd.load) state_nxt = ST_WB;
      ST_WB:   if (cmd.commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/xsrfb_dp.sv
// Datapath of the framebuffer: row-wide pixel memory, per-row blank flags,
// sprite XOR and collision logic, result register. Depends on xsrfb_pkg.
`default_nettype none

module xsrfb_dp #(
  parameter int unsigned WIDTH  = xsrfb_pkg::DEF_WIDTH,
  parameter int unsigned HEIGHT = xsrfb_pkg::DEF_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire xsrfb_pkg::dp_cmd_t cmd,
  input  wire logic [1:0]        in_action,
  input  wire logic [7:0]        in_pixel_x,
  input  wire logic [7:0]        in_pixel_y,
  input  wire logic [7:0]        in_sprite_bits,
  output logic                   out_collision,
  output logic [7:0]             out_read_byte
);
  import xsrfb_pkg::*;

  localparam int unsigned RowBytes = (WIDTH + 7) / 8;
  localparam int unsigned YAw      = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam logic [8:0]  WidthW   = 9'(WIDTH);
  localparam logic [8:0]  HeightW  = 9'(HEIGHT);

  typedef logic [RowBytes-1:0][7:0] row_t;

  row_t             mem [HEIGHT];
  logic [HEIGHT-1:0] row_vld_r;

  logic [1:0]   act_r;
  logic [7:0]   x_r, y_r, bits_r;
  row_t         rd_row_r;
  logic         rd_vld_r;
  logic         coll_r;
  logic [7:0]   rdb_r;

  logic [YAw-1:0] rd_addr, wr_addr;
  logic           in_y_on, on_scr;
  row_t           seen_row, new_row;
  logic [15:0]    win;
  logic           coll;
  logic [7:0]     rb;
  logic [5:0]     b_hi, b_lo;
  logic           do_draw, do_clear, do_read;

  assign in_y_on = {1'b0, in_pixel_y} < HeightW;
  assign rd_addr = in_y_on ? in_pixel_y[YAw-1:0] : '0;
  assign wr_addr = y_r[YAw-1:0];
  assign on_scr  = ({1'b0, x_r} < WidthW) && ({1'b0, y_r} < HeightW);

  assign do_draw  = cmd.commit && (act_r == ACT_DRAW) && on_scr;
  assign do_clear = cmd.commit && (act_r == ACT_CLEAR);
  assign do_read  = (act_r == ACT_READ) && on_scr;

  // Rows never written since the last clear read as blank.
  assign seen_row = rd_vld_r ? rd_row_r : '0;
  assign win      = {bits_r, 8'h00} >> x_r[2:0];
  assign b_hi     = {1'b0, x_r[7:3]};
  assign b_lo     = b_hi + 6'd1;

  always_comb begin
    logic [7:0] pat;
    coll    = 1'b0;
    rb      = 8'h00;
    new_row = seen_row;
    for (int j = 0; j < int'(RowBytes); j++) begin
      pat = 8'h00;
      if (b_hi == 6'(j)) pat = pat | win[15:8];
      if (b_lo == 6'(j)) pat = pat | win[7:0];
      pat        = pat & vis_mask(j, WIDTH);
      new_row[j] = seen_row[j] ^ pat;
      coll       = coll | (|(seen_row[j] & pat));
      if (b_hi == 6'(j)) rb = seen_row[j];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= in_action;
      x_r      <= in_pixel_x;
      y_r      <= in_pixel_y;
      bits_r   <= in_sprite_bits;
      rd_row_r <= mem[rd_addr];
      rd_vld_r <= row_vld_r[rd_addr];
    end
    if (do_draw) begin
      mem[wr_addr] <= new_row;
    end
    if (cmd.commit) begin
      coll_r <= (act_r == ACT_DRAW) && on_scr && coll;
      rdb_r  <= do_read ? rb : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (do_clear) begin
      row_vld_r <= '0;
    end else if (do_draw) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign out_collision = coll_r;
  assign out_read_byte = rdb_r;

endmodule

`default_nettype wire

>>> design/xor_sprite_row_framebuffer.sv
// Monochrome XOR sprite-row framebuffer, top level.
// A result is offered once its item, read with its row, has been written back.
// A new item is taken only after the last is written back; the single row memory
// is read on the transfer and written back once the result register is free.
// Reset: synchronous, active low; every row is marked blank at once, with no sweep.
`default_nettype none

module xor_sprite_row_framebuffer #(
  parameter int unsigned WIDTH  = xsrfb_pkg::DEF_WIDTH,
  parameter int unsigned HEIGHT = xsrfb_pkg::DEF_HEIGHT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  xsrfb_in_if.sink   in_ch,
  xsrfb_out_if.source out_ch
);
  import xsrfb_pkg::*;

  dp_cmd_t cmd;

  // The controller accepts an item only when idle. The item's row is read from
  // the memory on the transfer edge; in the write-back state, once the result
  // register is free, the datapath XORs the sprite into the row, writes it back and
  // loads the result register, which sits between the two sides, so a new item may
  // be transferred in while an earlier result still waits; only the write-back
  // stalls on a full result register.
  xsrfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // The memory holds one whole row per word, so a sprite row that spans two bytes
  // is a single read-modify-write. A clear drops every row's valid flag at once;
  // a row without its flag reads as blank.
  xsrfb_dp #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_action      (in_ch.action),
    .in_pixel_x     (in_ch.pixel_x),
    .in_pixel_y     (in_ch.pixel_y),
    .in_sprite_bits (in_ch.sprite_bits),
    .out_collision  (out_ch.collision),
    .out_read_byte  (out_ch.read_byte)
  );

  // The block is busy in the cycle after a transfer in.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ch.ready) else $error("input accepted during write-back");

  // A write-back always leaves a result on offer.
  a_commit_offers: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid) else $error("result lost after write-back");

  // Write-back happens only while the input side is closed.
  a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !in_ch.ready) else $error("write-back while idle");

  // A result carries a collision or a read byte, never both.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.collision && (out_ch.read_byte != 8'h00)))
    else $error("collision and read byte both set");

endmodule

`default_nettype wire
